// ===== rtl/lstq_pkg.sv =====
// Shared types and codes for the least-slack task queue.
package lstq_pkg;

  // Input commands
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_COMPLETE = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_INSERTED   = 3'd0;
  localparam logic [2:0] KIND_DROPPED    = 3'd1;
  localparam logic [2:0] KIND_DISPATCHED = 3'd2;
  localparam logic [2:0] KIND_NOTHING    = 3'd3;
  localparam logic [2:0] KIND_FULL       = 3'd4;

  // Configuration register indexes
  localparam logic REG_FREQUENCY = 1'b0;
  localparam logic REG_SERVER    = 1'b1;

  // One waiting entry
  typedef struct packed {
    logic [48:0] key;
    logic [48:0] deadline;
    logic [15:0] id;
    logic [31:0] cycles;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       ins_start;
    logic       rd_prev;
    logic       shift;
    logic       ins_write;
    logic       rd_head;
    logic       pop;
    logic       set_busy;
    logic       clr_busy;
    logic       emit;
    logic [2:0] kind;
    logic       last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       pos_zero;
    logic       prev_greater;
    logic       count_zero;
    logic       busy;
    logic       late;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/least_slack_task_queue.sv =====
// Top level of the least-slack task queue: controller plus datapath.
// Tasks wait in a ring of QUEUE_DEPTH entries held in one RAM, sorted by slack.
// Each item is captured in the idle state and decoded in the cycle after. An insert
// then walks from the tail, reading and comparing each entry and moving back those of
// larger slack; an entry of smaller or equal slack, or reaching the head, stops the
// walk, and the new entry is written. A dispatch examines head entries in turn through
// the registered RAM read, dropping late ones until one is dispatched or the queue is
// empty. Completion and busy dispatch finish after the decode. The next item is taken
// as soon as the last result of the previous one sits in the output register.
module least_slack_task_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] task_number,
  input  logic [31:0] creation_tick,
  input  logic [31:0] tolerance_ticks,
  input  logic [31:0] required_cycles,
  input  logic [31:0] task_bytes,
  input  logic [31:0] now_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [15:0] out_task,
  output logic        expired,
  output logic [48:0] finish_cycle,
  output logic [7:0]  out_server,
  output logic [63:0] total_cycles,
  output logic [63:0] total_bytes,
  output logic [5:0]  queued,
  output logic        last
);

  lstq_pkg::cmd_t    cmd;
  lstq_pkg::status_t status;

  lstq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lstq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .task_number     (task_number),
    .creation_tick   (creation_tick),
    .tolerance_ticks (tolerance_ticks),
    .required_cycles (required_cycles),
    .task_bytes      (task_bytes),
    .now_tick        (now_tick),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .out_task        (out_task),
    .expired         (expired),
    .finish_cycle    (finish_cycle),
    .out_server      (out_server),
    .total_cycles    (total_cycles),
    .total_bytes     (total_bytes),
    .queued          (queued),
    .last            (last)
  );

endmodule

// ===== rtl/lstq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lstq_datapath.sv =====
// Datapath: circular entry store, slack arithmetic, totals and result register.
module lstq_datapath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lstq_pkg::cmd_t        cmd,
  output lstq_pkg::status_t     status,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [1:0]            command,
  input  logic [15:0]           task_number,
  input  logic [31:0]           creation_tick,
  input  logic [31:0]           tolerance_ticks,
  input  logic [31:0]           required_cycles,
  input  logic [31:0]           task_bytes,
  input  logic [31:0]           now_tick,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            kind,
  output logic [15:0]           out_task,
  output logic                  expired,
  output logic [48:0]           finish_cycle,
  output logic [7:0]            out_server,
  output logic [63:0]           total_cycles,
  output logic [63:0]           total_bytes,
  output logic [5:0]            queued,
  output logic                  last
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  logic [15:0]       freq;
  logic [7:0]        server;
  logic [1:0]        cmd_code;
  logic [15:0]       task_id;
  logic [31:0]       cycles;
  logic [31:0]       bytes;
  logic [48:0]       deadline;
  logic [47:0]       now_scaled;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  pos;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] ptr_prev;
  logic [ADDR_W-1:0] head_inc;
  logic [CNT_W:0]    tail_sum;
  logic [ADDR_W-1:0] tail;
  logic              busy;
  logic [63:0]       cyc_total;
  logic [63:0]       byte_total;
  logic [63:0]       cyc_total_next;
  logic [63:0]       byte_total_next;
  logic [64:0]       cyc_sum;
  logic [64:0]       byte_sum;
  logic [48:0]       key;
  logic [48:0]       need;
  lstq_pkg::entry_t  rd_entry;
  lstq_pkg::entry_t  new_entry;
  logic [lstq_pkg::ENTRY_W-1:0] rd_bits;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [lstq_pkg::ENTRY_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      freq   <= 16'd1;
      server <= 8'd0;
    end else if (cfg_write) begin
      if (cfg_index == lstq_pkg::REG_FREQUENCY) begin
        freq <= cfg_data;
      end else begin
        server <= cfg_data[7:0];
      end
    end
  end

  // Capture the item and scale its times
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_code   <= command;
      task_id    <= task_number;
      cycles     <= required_cycles;
      bytes      <= task_bytes;
      deadline   <= {16'd0, ({1'b0, creation_tick} + {1'b0, tolerance_ticks})} *
                    {33'd0, freq};
      now_scaled <= {16'd0, now_tick} * {32'd0, freq};
    end
  end

  // Address helpers around the ring
  assign ptr_prev = (ptr == '0) ? LAST_ADDR : ptr - 1'b1;
  assign head_inc = (head == LAST_ADDR) ? '0 : head + 1'b1;
  assign tail_sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, head} + {1'b0, count};
  assign tail     = (tail_sum >= {1'b0, DEPTH_CNT}) ?
                    ADDR_W'(tail_sum - {1'b0, DEPTH_CNT}) : ADDR_W'(tail_sum);

  // Slack key offset by 2^32 and the cycles needed from now
  assign key      = deadline + 49'h1_0000_0000 - {17'd0, cycles};
  assign rd_entry = lstq_pkg::entry_t'(rd_bits);
  assign need     = {1'b0, now_scaled} + {17'd0, rd_entry.cycles};

  assign new_entry.key      = key;
  assign new_entry.deadline = deadline;
  assign new_entry.id       = task_id;
  assign new_entry.cycles   = cycles;

  // Entry store
  assign ram_we    = cmd.shift | cmd.ins_write;
  assign ram_waddr = ptr;
  assign ram_wdata = cmd.shift ? rd_bits : new_entry;
  assign ram_re    = cmd.rd_prev | cmd.rd_head;
  assign ram_raddr = cmd.rd_head ? head : ptr_prev;

  lstq_ram #(
    .WIDTH (lstq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );

  // Saturating totals
  assign cyc_sum  = {1'b0, cyc_total} + {33'd0, cycles};
  assign byte_sum = {1'b0, byte_total} + {33'd0, bytes};
  always_comb begin
    cyc_total_next  = cyc_total;
    byte_total_next = byte_total;
    if (cmd.ins_write) begin
      cyc_total_next  = cyc_sum[64] ? '1 : cyc_sum[63:0];
      byte_total_next = byte_sum[64] ? '1 : byte_sum[63:0];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.ins_write) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  // Queue pointers, counters and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      busy       <= 1'b0;
      cyc_total  <= '0;
      byte_total <= '0;
    end else begin
      count      <= count_next;
      cyc_total  <= cyc_total_next;
      byte_total <= byte_total_next;
      if (cmd.pop) begin
        head <= head_inc;
      end
      if (cmd.set_busy) begin
        busy <= 1'b1;
      end else if (cmd.clr_busy) begin
        busy <= 1'b0;
      end
    end
  end

  // Insert position walks from the tail towards the head
  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      pos <= count;
      ptr <= tail;
    end else if (cmd.shift) begin
      pos <= pos - 1'b1;
      ptr <= ptr_prev;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind         <= cmd.kind;
      last         <= cmd.last;
      total_cycles <= cyc_total_next;
      total_bytes  <= byte_total_next;
      queued       <= 6'(count_next);
      out_task     <= 16'd0;
      expired      <= 1'b0;
      finish_cycle <= 49'd0;
      out_server   <= 8'd0;
      case (cmd.kind)
        lstq_pkg::KIND_INSERTED, lstq_pkg::KIND_FULL: begin
          out_task <= task_id;
        end
        lstq_pkg::KIND_DROPPED: begin
          out_task <= rd_entry.id;
          expired  <= ({1'b0, now_scaled} > rd_entry.deadline);
        end
        lstq_pkg::KIND_DISPATCHED: begin
          out_task     <= rd_entry.id;
          finish_cycle <= need;
          out_server   <= server;
        end
        default: begin
          out_task <= 16'd0;
        end
      endcase
    end
  end

  // Status towards the controller
  assign status.command      = cmd_code;
  assign status.full         = (count >= DEPTH_CNT);
  assign status.pos_zero     = (pos == '0);
  assign status.prev_greater = (rd_entry.key > key);
  assign status.count_zero   = (count == '0);
  assign status.busy         = busy;
  assign status.late         = (need > rd_entry.deadline);
  assign status.out_free     = !out_valid || out_ready;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT) else $error("entry count above depth");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free) else $error("result overwritten");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0) else $error("pop from empty queue");
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> count < DEPTH_CNT) else $error("insert into full queue");

endmodule

// ===== rtl/lstq_ctrl.sv =====
// Controller: sequences insert, dispatch and completion over the datapath.
module lstq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lstq_pkg::status_t status,
  output lstq_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_INS_CHK = 3'd2;
  localparam logic [2:0] S_INS_CMP = 3'd3;
  localparam logic [2:0] S_INS_WR  = 3'd4;
  localparam logic [2:0] S_DSP_CHK = 3'd5;
  localparam logic [2:0] S_DSP_CMP = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (status.command)
          lstq_pkg::CMD_INSERT: begin
            if (!status.full) begin
              cmd.ins_start = 1'b1;
              state_next    = S_INS_CHK;
            end else if (status.out_free) begin
              cmd.emit   = 1'b1;
              cmd.kind   = lstq_pkg::KIND_FULL;
              cmd.last   = 1'b1;
              state_next = S_IDLE;
            end
          end
          lstq_pkg::CMD_DISPATCH: begin
            if (!status.busy) begin
              state_next = S_DSP_CHK;
            end else if (status.out_free) begin
              cmd.emit   = 1'b1;
              cmd.kind   = lstq_pkg::KIND_NOTHING;
              cmd.last   = 1'b1;
              state_next = S_IDLE;
            end
          end
          lstq_pkg::CMD_COMPLETE: begin
            cmd.clr_busy = 1'b1;
            state_next   = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_INS_CHK: begin
        if (status.pos_zero) begin
          state_next = S_INS_WR;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status.prev_greater) begin
          cmd.shift  = 1'b1;
          state_next = S_INS_CHK;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        if (status.out_free) begin
          cmd.ins_write = 1'b1;
          cmd.emit      = 1'b1;
          cmd.kind      = lstq_pkg::KIND_INSERTED;
          cmd.last      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DSP_CHK: begin
        if (!status.count_zero) begin
          cmd.rd_head = 1'b1;
          state_next  = S_DSP_CMP;
        end else if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = lstq_pkg::KIND_NOTHING;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DSP_CMP: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.pop  = 1'b1;
          if (status.late) begin
            cmd.kind   = lstq_pkg::KIND_DROPPED;
            state_next = S_DSP_CHK;
          end else begin
            cmd.kind     = lstq_pkg::KIND_DISPATCHED;
            cmd.last     = 1'b1;
            cmd.set_busy = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== dv/lstq_checker.sv =====
// Scoreboard for the least-slack task queue: mirrors the queue and checks every result beat.
module lstq_checker #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] task_number,
  input  logic [31:0] creation_tick,
  input  logic [31:0] tolerance_ticks,
  input  logic [31:0] required_cycles,
  input  logic [31:0] task_bytes,
  input  logic [31:0] now_tick,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] out_task,
  input  logic        expired,
  input  logic [48:0] finish_cycle,
  input  logic [7:0]  out_server,
  input  logic [63:0] total_cycles,
  input  logic [63:0] total_bytes,
  input  logic [5:0]  queued,
  input  logic        last,
  output int          pending,
  output int          failures
);

  localparam logic [63:0] MASK49 = 64'h0001_FFFF_FFFF_FFFF;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] task_id;
    logic        expired;
    logic [48:0] finish;
    logic [7:0]  server;
    logic [63:0] cycles_sum;
    logic [63:0] bytes_sum;
    logic [5:0]  depth;
    logic        last;
  } outcome_t;

  // Mirror of the waiting queue and the registers
  logic [15:0] freq_reg;
  logic [7:0]  server_reg;
  logic [48:0] slack_q [QUEUE_DEPTH];
  logic [48:0] deadline_q [QUEUE_DEPTH];
  logic [15:0] id_q [QUEUE_DEPTH];
  logic [31:0] need_q [QUEUE_DEPTH];
  int          waiting;
  logic        running;
  logic [63:0] cycles_acc;
  logic [63:0] bytes_acc;
  outcome_t    awaited [$];
  int          fail_cnt;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  task automatic note(logic [2:0] k, logic [15:0] id, logic ex, logic [48:0] fin,
                      logic [7:0] srv, logic fin_flag);
    outcome_t o;
    o.kind = k; o.task_id = id; o.expired = ex; o.finish = fin; o.server = srv;
    o.cycles_sum = cycles_acc; o.bytes_sum = bytes_acc; o.depth = waiting[5:0];
    o.last = fin_flag;
    awaited.insert(awaited.size(), o);
  endtask

  task automatic take_head();
    for (int i = 1; i < waiting; i++) begin
      slack_q[i-1] = slack_q[i]; deadline_q[i-1] = deadline_q[i];
      id_q[i-1] = id_q[i]; need_q[i-1] = need_q[i];
    end
    waiting--;
  endtask

  // Work out the results that one accepted item causes
  task automatic schedule_item(logic [1:0] cmd, logic [15:0] tn, logic [31:0] cr,
                               logic [31:0] tol, logic [31:0] need, logic [31:0] nbytes,
                               logic [31:0] now);
    logic [63:0] dl, key, now_sc;
    int pos;
    if (cmd == lstq_pkg::CMD_INSERT) begin
      if (waiting >= QUEUE_DEPTH) begin
        note(lstq_pkg::KIND_FULL, tn, 1'b0, '0, '0, 1'b1);
      end else begin
        dl = ({32'd0, cr} + {32'd0, tol}) * {48'd0, freq_reg};
        key = (dl + 64'h1_0000_0000 - {32'd0, need}) & MASK49;
        pos = waiting;
        while (pos > 0 && {15'd0, slack_q[pos-1]} > key) begin
          slack_q[pos] = slack_q[pos-1]; deadline_q[pos] = deadline_q[pos-1];
          id_q[pos] = id_q[pos-1]; need_q[pos] = need_q[pos-1];
          pos--;
        end
        slack_q[pos] = key[48:0];
        deadline_q[pos] = dl[48:0];
        id_q[pos] = tn;
        need_q[pos] = need;
        waiting++;
        cycles_acc = add_sat(cycles_acc, {32'd0, need});
        bytes_acc = add_sat(bytes_acc, {32'd0, nbytes});
        note(lstq_pkg::KIND_INSERTED, tn, 1'b0, '0, '0, 1'b1);
      end
    end else if (cmd == lstq_pkg::CMD_DISPATCH) begin
      now_sc = {32'd0, now} * {48'd0, freq_reg};
      if (running) begin
        note(lstq_pkg::KIND_NOTHING, '0, 1'b0, '0, '0, 1'b1);
      end else begin
        // drop every head that cannot finish in time
        while (waiting > 0 && now_sc + {32'd0, need_q[0]} > {15'd0, deadline_q[0]}) begin
          logic [15:0] id;
          logic ex;
          id = id_q[0];
          ex = now_sc > {15'd0, deadline_q[0]};
          take_head();
          note(lstq_pkg::KIND_DROPPED, id, ex, '0, '0, 1'b0);
        end
        if (waiting > 0) begin
          logic [15:0] id;
          logic [63:0] fin;
          id = id_q[0];
          fin = now_sc + {32'd0, need_q[0]};
          take_head();
          running = 1'b1;
          note(lstq_pkg::KIND_DISPATCHED, id, 1'b0, fin[48:0], server_reg, 1'b1);
        end else begin
          note(lstq_pkg::KIND_NOTHING, '0, 1'b0, '0, '0, 1'b1);
        end
      end
    end else if (cmd == lstq_pkg::CMD_COMPLETE) begin
      running = 1'b0;
    end
  endtask

  task automatic mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      freq_reg = 16'd1;
      server_reg = 8'd0;
      waiting = 0;
      running = 1'b0;
      cycles_acc = '0;
      bytes_acc = '0;
      awaited.delete();
      fail_cnt = 0;
    end else begin
      // register writes
      if (cfg_write) begin
        if (cfg_index == lstq_pkg::REG_FREQUENCY) freq_reg = cfg_data;
        else server_reg = cfg_data[7:0];
      end
      // compare the result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: result with none expected, kind %0d task %0d", $time, kind, out_task);
          fail_cnt++;
        end else begin
          outcome_t o;
          o = awaited[0];
          awaited.delete(0);
          if (kind !== o.kind) mismatch("kind", 64'(o.kind), 64'(kind));
          if (out_task !== o.task_id) mismatch("out_task", 64'(o.task_id), 64'(out_task));
          if (expired !== o.expired) mismatch("expired", 64'(o.expired), 64'(expired));
          if (finish_cycle !== o.finish)
            mismatch("finish_cycle", 64'(o.finish), 64'(finish_cycle));
          if (out_server !== o.server)
            mismatch("out_server", 64'(o.server), 64'(out_server));
          if (total_cycles !== o.cycles_sum)
            mismatch("total_cycles", o.cycles_sum, total_cycles);
          if (total_bytes !== o.bytes_sum) mismatch("total_bytes", o.bytes_sum, total_bytes);
          if (queued !== o.depth) mismatch("queued", 64'(o.depth), 64'(queued));
          if (last !== o.last) mismatch("last", 64'(o.last), 64'(last));
        end
      end
      // predict from the accepted input beat
      if (in_valid && in_ready)
        schedule_item(command, task_number, creation_tick, tolerance_ticks,
                      required_cycles, task_bytes, now_tick);
    end
    pending <= awaited.size();
    failures <= fail_cnt;
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the least-slack task queue testbench: clock, reset, stimulus and verdict.
module testbench;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [15:0] task_number = '0;
  logic [31:0] creation_tick = '0;
  logic [31:0] tolerance_ticks = '0;
  logic [31:0] required_cycles = '0;
  logic [31:0] task_bytes = '0;
  logic [31:0] now_tick = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [15:0] out_task;
  logic        expired;
  logic [48:0] finish_cycle;
  logic [7:0]  out_server;
  logic [63:0] total_cycles;
  logic [63:0] total_bytes;
  logic [5:0]  queued;
  logic        last;
  int          pending;
  int          failures;
  int          cycle_count = 0;
  bit          steady_send = 1'b0;
  bit          steady_take = 1'b0;

  least_slack_task_queue #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  lstq_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each beat, none in the steady phase
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady_take ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Present one item; valid stays high across back-to-back beats
  task automatic send(logic [1:0] cmd, logic [15:0] tn, logic [31:0] cr, logic [31:0] tol,
                      logic [31:0] need, logic [31:0] nbytes, logic [31:0] now);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd; task_number <= tn; creation_tick <= cr; tolerance_ticks <= tol;
    required_cycles <= need; task_bytes <= nbytes; now_tick <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] freq, logic [7:0] srv);
    cfg_write <= 1'b1; cfg_index <= lstq_pkg::REG_FREQUENCY; cfg_data <= freq;
    @(posedge clk);
    cfg_index <= lstq_pkg::REG_SERVER; cfg_data <= {8'd0, srv};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One random item around a base tick so that drops and dispatches both happen
  task automatic random_item(int insert_pct, logic [31:0] base, logic [15:0] freq);
    int pick;
    logic [1:0] cmd;
    logic [31:0] cr, tol, need, now;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) cmd = lstq_pkg::CMD_INSERT;
    else if (pick < insert_pct + (100 - insert_pct) / 2) cmd = lstq_pkg::CMD_DISPATCH;
    else if (pick < 96) cmd = lstq_pkg::CMD_COMPLETE;
    else cmd = lstq_pkg::CMD_NONE;
    if ($urandom_range(0, 99) < 15) begin
      cr = $urandom; tol = $urandom; need = $urandom; now = $urandom;
    end else begin
      cr = base + $urandom_range(0, 50);
      tol = $urandom_range(0, 60);
      need = $urandom_range(0, 40 * (freq + 1));
      now = base + $urandom_range(0, 100);
    end
    send(cmd, 16'($urandom_range(0, 65535)), cr, tol, need, $urandom, now);
  endtask

  initial begin
    logic [15:0] freqs [5];
    logic [7:0]  servers [5];
    int          mixes [5];
    logic [31:0] base;
    freqs = '{16'd1, 16'd65535, 16'd0, 16'd1000, 16'd3};
    servers = '{8'd0, 8'd255, 8'd7, 8'd128, 8'd1};
    mixes = '{50, 85, 50, 40, 60};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle server, ignored command, field extremes, ties, busy dispatch
    set_regs(16'd1, 8'd0);
    send(lstq_pkg::CMD_DISPATCH, 16'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
    send(lstq_pkg::CMD_COMPLETE, 16'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
    send(lstq_pkg::CMD_NONE, 16'hFFFF, '1, '1, '1, '1, '1);
    send(lstq_pkg::CMD_INSERT, 16'hFFFF, '1, '1, '1, '1, '0);
    send(lstq_pkg::CMD_INSERT, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send(lstq_pkg::CMD_INSERT, 16'd10, 32'd100, 32'd20, 32'd5, 32'd64, 32'd0);
    send(lstq_pkg::CMD_INSERT, 16'd11, 32'd100, 32'd20, 32'd5, 32'd64, 32'd0);
    send(lstq_pkg::CMD_INSERT, 16'd12, 32'd50, 32'd0, 32'd1, 32'd8, 32'd0);
    send(lstq_pkg::CMD_DISPATCH, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send(lstq_pkg::CMD_DISPATCH, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send(lstq_pkg::CMD_COMPLETE, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send(lstq_pkg::CMD_DISPATCH, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd110);
    send(lstq_pkg::CMD_COMPLETE, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send(lstq_pkg::CMD_DISPATCH, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send(lstq_pkg::CMD_COMPLETE, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    drain();

    // Random phases, one register setting each
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(freqs[ph], servers[ph]);
      steady_send = (ph == 3);
      steady_take = (ph == 4);
      base = $urandom_range(0, 32'hFFFF_0000);
      for (int n = 0; n < 92; n++) begin
        if (n % 30 == 29) base = base + $urandom_range(0, 200);
        random_item(mixes[ph], base, freqs[ph]);
      end
      // drop the late entries and free the server before the next setting
      send(lstq_pkg::CMD_COMPLETE, 16'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
      send(lstq_pkg::CMD_DISPATCH, 16'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF);
      send(lstq_pkg::CMD_COMPLETE, 16'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
      drain();
    end

    if (failures == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lstq_pkg.sv
rtl/lstq_ram.sv
rtl/lstq_datapath.sv
rtl/lstq_ctrl.sv
rtl/least_slack_task_queue.sv
dv/lstq_checker.sv
dv/testbench.sv
